// ===== rtl/lfms_pkg.sv =====
// Shared types and constants of the liquid fraction map with region statistics.
`timescale 1ns / 1ps

package lfms_pkg;

	localparam int FRAC_W            = 16;
	localparam int STAT_W            = 24;
	localparam int SOLID_W           = 18;
	localparam int GAIN_W            = 32;
	localparam int PROD_W            = SOLID_W + GAIN_W;
	localparam int OFFSET_W          = 29;
	localparam int MAX_REGION_PIXELS = 16777216;

	localparam logic [OFFSET_W-1:0] OFFSET_Q14  = 29'd327680000;
	localparam logic [GAIN_W-1:0]   GAIN_RESET  = 32'd4096;
	localparam logic [SOLID_W-1:0]  SOLID_RESET = 18'd0;
	localparam logic [FRAC_W-1:0]   FRAC_MAX    = 16'hFFFF;

	typedef enum logic [0:0] {
		CFG_SOLID_LEVEL = 1'b0,
		CFG_GAIN        = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] pixel_value;
		logic        last_pixel;
	} in_item_t;

	typedef struct packed {
		logic [15:0] fraction_pixel;
		logic        stats_valid;
		logic [23:0] region_mean;
		logic [23:0] region_spread;
	} out_item_t;

endpackage

// ===== rtl/lfms_fifo.sv =====
// Small register queue between the mapping front and the statistics back.
`timescale 1ns / 1ps

module lfms_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign full     = (count_q == CNTW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// store entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");
`endif

endmodule

// ===== rtl/lfms_front.sv =====
// Front: config registers, pixel mapping pipeline and region accumulators.
`timescale 1ns / 1ps

module lfms_front #(
	parameter int MAX_PIX = lfms_pkg::MAX_REGION_PIXELS,
	parameter int CW = $clog2(MAX_PIX + 1),
	parameter int SW = CW + 16,
	parameter int QW = CW + 32,
	parameter int EW = 17 + CW + SW + QW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  lfms_pkg::in_item_t in_data,
	output logic               q_push,
	output logic [EW-1:0]      q_data,
	input  logic               q_full
);

	logic [lfms_pkg::SOLID_W-1:0] solid_q;
	logic [lfms_pkg::GAIN_W-1:0]  gain_q;

	logic                         v_s1, v_s2, v_s3, v_s4;
	logic                         last_s1, last_s2, last_s3, last_s4;
	logic                         neg_s1, neg_s2;
	logic [lfms_pkg::SOLID_W-1:0] mag_s1;
	logic [lfms_pkg::PROD_W-1:0]  prod_s2;
	logic [15:0]                  f_s3, f_s4;
	logic [31:0]                  sq_s4;

	logic [CW-1:0] cnt_q, cnt_nx;
	logic [SW-1:0] sum_q, sum_nx;
	logic [QW-1:0] sqs_q, sqs_nx;

	logic                         advance;
	logic [lfms_pkg::SOLID_W-1:0] p4;
	logic [lfms_pkg::PROD_W:0]    t_pos;
	logic [lfms_pkg::OFFSET_W-1:0] t_neg;
	logic [15:0]                  f_map;

	// stall the whole front only when the last stage cannot enter the queue
	assign advance  = !(v_s4 && q_full);
	assign in_ready = advance;
	assign q_push   = v_s4 && !q_full;

	// write config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solid_q <= lfms_pkg::SOLID_RESET;
			gain_q  <= lfms_pkg::GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				lfms_pkg::CFG_SOLID_LEVEL: solid_q <= cfg_data[lfms_pkg::SOLID_W-1:0];
				lfms_pkg::CFG_GAIN:        gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// map the product to a coded fraction with clamping
	always_comb begin
		p4    = {in_data.pixel_value, 2'b00};
		t_pos = (lfms_pkg::PROD_W+1)'(prod_s2) + (lfms_pkg::PROD_W+1)'(lfms_pkg::OFFSET_Q14);
		t_neg = lfms_pkg::OFFSET_Q14 - prod_s2[lfms_pkg::OFFSET_W-1:0];
		if (!neg_s2) begin
			if (|t_pos[lfms_pkg::PROD_W:30]) begin
				f_map = lfms_pkg::FRAC_MAX;
			end else begin
				f_map = t_pos[29:14];
			end
		end else if (prod_s2 > lfms_pkg::PROD_W'(lfms_pkg::OFFSET_Q14)) begin
			f_map = '0;
		end else begin
			f_map = {1'b0, t_neg[28:14]};
		end
	end

	// advance the mapping pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (p4 >= solid_q) begin
				mag_s1 <= p4 - solid_q;
				neg_s1 <= 1'b0;
			end else begin
				mag_s1 <= solid_q - p4;
				neg_s1 <= 1'b1;
			end
			last_s1 <= in_data.last_pixel;
			prod_s2 <= lfms_pkg::PROD_W'(mag_s1) * lfms_pkg::PROD_W'(gain_q);
			neg_s2  <= neg_s1;
			last_s2 <= last_s1;
			f_s3    <= f_map;
			last_s3 <= last_s2;
			f_s4    <= f_s3;
			sq_s4   <= 32'(f_s3) * 32'(f_s3);
			last_s4 <= last_s3;
		end
	end

	// accumulate until the count saturates
	always_comb begin
		cnt_nx = cnt_q;
		sum_nx = sum_q;
		sqs_nx = sqs_q;
		if (cnt_q < CW'(MAX_PIX)) begin
			cnt_nx = cnt_q + 1'b1;
			sum_nx = sum_q + SW'(f_s4);
			sqs_nx = sqs_q + QW'(sq_s4);
		end
	end

	assign q_data = {f_s4, last_s4, cnt_nx, sum_nx, sqs_nx};

	// update or clear accumulators as items enter the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			sqs_q <= '0;
		end else if (q_push) begin
			if (last_s4) begin
				cnt_q <= '0;
				sum_q <= '0;
				sqs_q <= '0;
			end else begin
				cnt_q <= cnt_nx;
				sum_q <= sum_nx;
				sqs_q <= sqs_nx;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_PIX))
		else $error("pixel count above region limit");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && last_s4) |=> (cnt_q == '0))
		else $error("accumulators not cleared after last pixel");
`endif

endmodule

// ===== rtl/lfms_back.sv =====
// Back: passes mapped pixels and computes region mean and spread on the last one.
`timescale 1ns / 1ps

module lfms_back #(
	parameter int CW = 25,
	parameter int SW = CW + 16,
	parameter int QW = CW + 32,
	parameter int EW = 17 + CW + SW + QW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [EW-1:0]       q_data,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output lfms_pkg::out_item_t out_data
);

	localparam int PW  = CW + QW;
	localparam int DW  = PW + 1;
	localparam int TW  = DW + 17;
	localparam int RW  = TW / 2;
	localparam int IW  = $clog2(RW + 1);
	localparam int QTW = lfms_pkg::STAT_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MULA = 7'b0000010,
		ST_MULB = 7'b0000100,
		ST_SQRT = 7'b0001000,
		ST_DIVS = 7'b0010000,
		ST_DIVM = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	logic [15:0]        e_f;
	logic               e_last;
	logic [CW-1:0]      e_n;
	logic [SW-1:0]      e_s;
	logic [QW-1:0]      e_sq;

	logic [15:0]        f_q;
	logic [CW-1:0]      n_q;
	logic [SW-1:0]      s_q;
	logic [IW-1:0]      it_q;
	logic [PW-1:0]      mcand_q;
	logic [SW-1:0]      mplier_q;
	logic signed [DW-1:0] acc_q, acc_nx;
	logic [TW-1:0]      x_q;
	logic [RW-1:0]      root_q, root_nx;
	logic [RW+1:0]      srem_q, srem_nx;
	logic [RW+3:0]      rem_sh;
	logic [RW+1:0]      trial;
	logic [QTW-1:0]     dvd_q;
	logic [CW-1:0]      drem_q, drem_nx;
	logic [CW:0]        r2;
	logic [QTW-1:0]     quo_q, quo_nx;
	logic [QTW-1:0]     spread_q, mean_q;
	logic               slot_free;
	logic               out_valid_q;
	lfms_pkg::out_item_t out_q;

	assign {e_f, e_last, e_n, e_s, e_sq} = q_data;
	assign slot_free = !out_valid_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty && slot_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// one step of the shared shift-add, root and divide units
	always_comb begin
		acc_nx = acc_q;
		if (mplier_q[0]) begin
			if (state_q == ST_MULA) begin
				acc_nx = acc_q + $signed(DW'(mcand_q));
			end else begin
				acc_nx = acc_q - $signed(DW'(mcand_q));
			end
		end
		rem_sh = {srem_q, x_q[TW-1:TW-2]};
		trial  = {root_q, 2'b01};
		if (rem_sh >= (RW+4)'(trial)) begin
			srem_nx = (RW+2)'(rem_sh - (RW+4)'(trial));
			root_nx = {root_q[RW-2:0], 1'b1};
		end else begin
			srem_nx = rem_sh[RW+1:0];
			root_nx = {root_q[RW-2:0], 1'b0};
		end
		r2 = {drem_q, dvd_q[QTW-1]};
		if (r2 >= {1'b0, n_q}) begin
			drem_nx = CW'(r2 - {1'b0, n_q});
			quo_nx  = {quo_q[QTW-2:0], 1'b1};
		end else begin
			drem_nx = r2[CW-1:0];
			quo_nx  = {quo_q[QTW-2:0], 1'b0};
		end
	end

	// sequence the statistics work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (e_last) begin
							state_q <= ST_MULA;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_MULA: if (it_q == '0) state_q <= ST_MULB;
				ST_MULB: if (it_q == '0) state_q <= ST_SQRT;
				ST_SQRT: if (it_q == '0) state_q <= ST_DIVS;
				ST_DIVS: if (it_q == '0) state_q <= ST_DIVM;
				ST_DIVM: if (it_q == '0) state_q <= ST_DONE;
				ST_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					f_q      <= e_f;
					n_q      <= e_n;
					s_q      <= e_s;
					mcand_q  <= PW'(e_sq);
					mplier_q <= SW'(e_n);
					acc_q    <= '0;
					it_q     <= IW'(CW - 1);
					out_q    <= '{fraction_pixel: e_f, stats_valid: 1'b0,
						region_mean: '0, region_spread: '0};
				end
			end
			ST_MULA: begin
				acc_q <= acc_nx;
				if (it_q == '0) begin
					mcand_q  <= PW'(s_q);
					mplier_q <= s_q;
					it_q     <= IW'(SW - 1);
				end else begin
					mcand_q  <= {mcand_q[PW-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
					it_q     <= it_q - 1'b1;
				end
			end
			ST_MULB: begin
				acc_q    <= acc_nx;
				mcand_q  <= {mcand_q[PW-2:0], 1'b0};
				mplier_q <= mplier_q >> 1;
				it_q     <= it_q - 1'b1;
				if (it_q == '0) begin
					// scale the variance numerator by 2^16 for a Q8 root
					if (acc_nx[DW-1]) begin
						x_q <= '0;
					end else begin
						x_q <= {2'b00, acc_nx[DW-2:0], 16'h0000};
					end
					root_q <= '0;
					srem_q <= '0;
					it_q   <= IW'(RW - 1);
				end
			end
			ST_SQRT: begin
				x_q    <= {x_q[TW-3:0], 2'b00};
				root_q <= root_nx;
				srem_q <= srem_nx;
				it_q   <= it_q - 1'b1;
				if (it_q == '0) begin
					// quotient fits 24 bits, so the upper dividend part is below n
					drem_q <= root_nx[CW+QTW-1:QTW];
					dvd_q  <= root_nx[QTW-1:0];
					quo_q  <= '0;
					it_q   <= IW'(QTW - 1);
				end
			end
			ST_DIVS: begin
				drem_q <= drem_nx;
				dvd_q  <= {dvd_q[QTW-2:0], 1'b0};
				quo_q  <= quo_nx;
				it_q   <= it_q - 1'b1;
				if (it_q == '0) begin
					spread_q <= quo_nx;
					drem_q   <= s_q[SW-1:16];
					dvd_q    <= {s_q[15:0], 8'h00};
					quo_q    <= '0;
					it_q     <= IW'(QTW - 1);
				end
			end
			ST_DIVM: begin
				drem_q <= drem_nx;
				dvd_q  <= {dvd_q[QTW-2:0], 1'b0};
				quo_q  <= quo_nx;
				it_q   <= it_q - 1'b1;
				if (it_q == '0) begin
					mean_q <= quo_nx;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					out_q <= '{fraction_pixel: f_q, stats_valid: 1'b1,
						region_mean: mean_q, region_spread: spread_q};
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_pop_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE))
		else $error("queue popped while statistics busy");
	a_stats_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && out_q.stats_valid) |-> ($past(state_q) == ST_DONE))
		else $error("statistics result not from final step");
`endif

endmodule

// ===== rtl/liquid_fraction_map_with_stats.sv =====
// Top level: liquid fraction mapping with per-region mean and spread.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index (0 solid_level, 1 gain), cfg_data
//  in      | in_valid / in_ready   | in_data: pixel_value, last_pixel
//  out     | out_valid / out_ready | out_data: fraction_pixel, stats, mean, spread
//
// Ordinary pixels stream at one item per cycle, unless the queue is full, through a
// four-stage mapping pipe (difference, multiply, clamp, square), with a four-entry
// queue to the back end. A last pixel holds the back end through a serial multiply,
// a bit-pair square root and two 24-step divides.
// Reset clears accumulators, queue and control and loads solid_level 0, gain 4096.
// The front stalls only when the queue is full; the back stalls on out_ready.
`timescale 1ns / 1ps

module liquid_fraction_map_with_stats #(
	parameter int MAX_REGION_PIXELS = lfms_pkg::MAX_REGION_PIXELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  lfms_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lfms_pkg::out_item_t out_data
);

	localparam int CW = $clog2(MAX_REGION_PIXELS + 1);
	localparam int SW = CW + 16;
	localparam int QW = CW + 32;
	localparam int EW = 17 + CW + SW + QW;

	logic          q_push, q_full, q_pop, q_empty;
	logic [EW-1:0] q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	lfms_front #(
		.MAX_PIX(MAX_REGION_PIXELS), .CW(CW), .SW(SW), .QW(QW), .EW(EW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.q_full    (q_full)
	);

	lfms_fifo #(
		.WIDTH(EW), .DEPTH(4)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	lfms_back #(
		.CW(CW), .SW(SW), .QW(QW), .EW(EW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_rdata),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== verif/liquid_fraction_map_with_stats_tb.sv =====
// Testbench for the liquid fraction map with per-region mean and spread.
`timescale 1ns / 1ps

// Predicts coded fractions and region statistics, and compares them with the block's results.
class fraction_scoreboard;
	logic [17:0]          solid;
	logic [31:0]          gain;
	logic [24:0]          count;
	logic [39:0]          sum;
	logic [55:0]          sq_sum;
	lfms_pkg::out_item_t  expected_q[$];
	int                   mismatches;
	int                   checked;
	int                   regions;

	function new();
		solid      = lfms_pkg::SOLID_RESET;
		gain       = lfms_pkg::GAIN_RESET;
		count      = '0;
		sum        = '0;
		sq_sum     = '0;
		mismatches = 0;
		checked    = 0;
		regions    = 0;
	endfunction

	function void write_reg(lfms_pkg::cfg_reg_t idx, logic [31:0] data);
		if (idx == lfms_pkg::CFG_SOLID_LEVEL)
			solid = data[17:0];
		else
			gain = data;
	endfunction

	// Map one gray level by the linear calibration, clamped to 16 bits.
	function logic [15:0] map_gray(logic [15:0] pix);
		logic [63:0] p4;
		logic [63:0] t;
		logic [63:0] prod;
		p4 = {46'd0, pix, 2'b00};
		if (p4 >= {46'd0, solid}) begin
			t = (p4 - solid) * gain + 64'(lfms_pkg::OFFSET_Q14);
		end else begin
			prod = ({46'd0, solid} - p4) * gain;
			if (prod > 64'(lfms_pkg::OFFSET_Q14))
				return 16'd0;
			t = 64'(lfms_pkg::OFFSET_Q14) - prod;
		end
		t = t >> 14;
		return (t > 64'd65535) ? 16'hFFFF : t[15:0];
	endfunction

	// Bit-serial root of (n*sq - s*s) scaled by 2^16, found against n.
	function logic [23:0] spread_of(logic [127:0] n, logic [127:0] s, logic [127:0] sq);
		logic [127:0] a;
		logic [127:0] b;
		logic [127:0] target;
		logic [127:0] c;
		logic [127:0] x;
		logic [127:0] res;
		a = n * sq;
		b = s * s;
		if (a < b)
			return 24'd0;
		target = (a - b) << 16;
		res = '0;
		for (int bt = 23; bt >= 0; bt--) begin
			c = res | (128'd1 << bt);
			x = c * n;
			if (x * x <= target)
				res = c;
		end
		return res[23:0];
	endfunction

	function void note_pixel(lfms_pkg::in_item_t it);
		lfms_pkg::out_item_t e;
		logic [47:0] scaled;
		e = '0;
		e.fraction_pixel = map_gray(it.pixel_value);
		// Hold the accumulators once the region is at its maximum length.
		if (count < lfms_pkg::MAX_REGION_PIXELS) begin
			count  = count + 25'd1;
			sum    = sum + e.fraction_pixel;
			sq_sum = sq_sum + e.fraction_pixel * e.fraction_pixel;
		end
		if (it.last_pixel) begin
			scaled          = {sum, 8'd0};
			e.stats_valid   = 1'b1;
			e.region_mean   = 24'(scaled / count);
			e.region_spread = spread_of(128'(count), 128'(sum), 128'(sq_sum));
			count  = '0;
			sum    = '0;
			sq_sum = '0;
			regions++;
		end
		expected_q.push_back(e);
	endfunction

	function void check_result(lfms_pkg::out_item_t got);
		lfms_pkg::out_item_t e;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h", got);
			return;
		end
		e = expected_q.pop_front();
		checked++;
		if (got.fraction_pixel !== e.fraction_pixel || got.stats_valid !== e.stats_valid ||
		    got.region_mean !== e.region_mean || got.region_spread !== e.region_spread) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"result %0d: expected frac %0d valid %0d mean %0d spread %0d,",
					" got frac %0d valid %0d mean %0d spread %0d"},
					checked, e.fraction_pixel, e.stats_valid, e.region_mean, e.region_spread,
					got.fraction_pixel, got.stats_valid, got.region_mean, got.region_spread);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module liquid_fraction_map_with_stats_tb;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int SETTLE       = 250;

	logic      clk;
	logic      arst_n;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;
	logic      in_valid;
	logic      in_ready;
	lfms_pkg::in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	lfms_pkg::out_item_t out_data;

	fraction_scoreboard sb;
	logic      steady;
	int        cycles;
	int        pixels_sent;

	liquid_fraction_map_with_stats u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Stall the result side now and then, except in the steady stretch.
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 6);
	end

	// Check each accepted result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_pixel(input logic [15:0] pix, input logic last);
		lfms_pkg::in_item_t it;
		it.pixel_value = pix;
		it.last_pixel  = last;
		if (!steady && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(it);
		pixels_sent++;
	endtask

	// Pause until every result is back and the stats engine is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Present one register write and wait for its acceptance.
	task automatic write_reg(input lfms_pkg::cfg_reg_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(input logic [17:0] solid, input logic [31:0] g);
		drain();
		write_reg(lfms_pkg::CFG_SOLID_LEVEL, {14'd0, solid});
		write_reg(lfms_pkg::CFG_GAIN, g);
		cfg_valid <= 1'b0;
	endtask

	// Send one region of the given length around a random gray level, with some outliers.
	task automatic send_region(input int len);
		logic [15:0] base;
		logic [15:0] pix;
		base = $urandom_range(65535);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				pix = $urandom_range(65535);
			else
				pix = 16'(int'(base) + $urandom_range(2000) - 1000);
			send_pixel(pix, i == len - 1);
		end
	endtask

	initial begin
		logic [17:0] solid;
		logic [31:0] g;
		int          sel;
		sb          = new();
		steady      = 1'b0;
		cycles      = 0;
		pixels_sent = 0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = lfms_pkg::CFG_SOLID_LEVEL;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset calibration, field extremes, single-pixel region.
		send_pixel(16'd0, 1'b0);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'd12345, 1'b1);
		send_pixel(16'd1, 1'b0);
		send_pixel(16'h8000, 1'b0);
		send_pixel(16'h7FFF, 1'b1);
		// Solid level above every pixel with huge gain: clamp to zero.
		configure(18'h3FFFF, 32'hFFFFFFFF);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'd0, 1'b1);
		// Zero solid level with huge gain: nonzero pixels saturate high.
		configure(18'd0, 32'hFFFFFFFF);
		send_pixel(16'd0, 1'b0);
		send_pixel(16'd1, 1'b0);
		send_pixel(16'hFFFF, 1'b1);
		// Zero gain maps everything to the offset.
		configure(18'd40000, 32'd0);
		send_pixel(16'd0, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'd10000, 1'b1);
		// Solid slightly above the first two pixels: small negative difference lowers value.
		configure(18'd4001, 32'd2048);
		send_pixel(16'd1000, 1'b0);
		send_pixel(16'd999, 1'b0);
		send_pixel(16'd40000, 1'b1);

		// Random phases, each with a fresh calibration.
		for (int phase = 0; phase < 8; phase++) begin
			sel = $urandom_range(4);
			case (sel)
				0: begin
					solid = $urandom_range(262143);
					g     = $urandom;
				end
				1: begin
					solid = 18'h3FFFF;
					g     = $urandom_range(8000, 100);
				end
				default: begin
					solid = $urandom_range(262143);
					g     = $urandom_range(30000, 100);
				end
			endcase
			configure(solid, g);
			steady = (phase == 4);
			while (pixels_sent < 200 * (phase + 1) + 20)
				send_region(($urandom_range(3) == 0) ? $urandom_range(60, 1)
					: $urandom_range(16, 1));
			steady = 1'b0;
		end

		drain();
		$display("sent %0d pixels in %0d regions over %0d cycles", pixels_sent, sb.regions, cycles);
		$display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
